// ===== src/led_matrix_glyph_blit_and_scan_unit_defines.svh =====
// Assertion helpers for the checker file.
`ifndef LED_MATRIX_GLYPH_BLIT_AND_SCAN_UNIT_DEFINES_SVH
`define LED_MATRIX_GLYPH_BLIT_AND_SCAN_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, idle during reset
`define LMGBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk_i, idle during reset
`define LMGBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lmgbs_pkg.sv =====
`default_nettype none

package lmgbs_pkg;

  // Frame geometry
  localparam int SCAN_ROWS = 8;
  localparam int ROW_W     = $clog2(SCAN_ROWS);
  localparam int PIX_W     = 8;
  localparam int GLYPH_ROWS = 7;

  // Command codes
  localparam logic [2:0] FUNC_SET   = 3'd0;
  localparam logic [2:0] FUNC_CLR   = 3'd1;
  localparam logic [2:0] FUNC_CLEAR = 3'd2;
  localparam logic [2:0] FUNC_BLIT  = 3'd3;
  localparam logic [2:0] FUNC_TICK  = 3'd4;

  // Row select bits that are inactive (high) on a tick
  localparam logic [7:0] ROW_SEL_IDLE = 8'hFF;

  typedef struct packed {
    logic [2:0]        func;
    logic [2:0]        col;
    logic [2:0]        row;
    logic [7:0]        char_code;
    logic signed [7:0] shift_amount;
  } in_t;

  typedef struct packed {
    logic [15:0] drive_word;
    logic [3:0]  glyph_width;
  } out_t;

  typedef struct packed {
    logic [3:0]                        width;
    logic [GLYPH_ROWS-1:0][PIX_W-1:0] rows;
  } glyph_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PIX,
    S_TICK,
    S_MASK,
    S_BLIT,
    S_DONE
  } state_e;

  function automatic glyph_t mk(input logic [3:0] w, input logic [7:0] r0,
                                input logic [7:0] r1, input logic [7:0] r2,
                                input logic [7:0] r3, input logic [7:0] r4,
                                input logic [7:0] r5, input logic [7:0] r6);
    glyph_t g;
    g.width   = w;
    g.rows[0] = r0;
    g.rows[1] = r1;
    g.rows[2] = r2;
    g.rows[3] = r3;
    g.rows[4] = r4;
    g.rows[5] = r5;
    g.rows[6] = r6;
    return g;
  endfunction

  // Font ROM: width and seven rows per code, empty for unlisted codes
  function automatic glyph_t glyph_rom(input logic [7:0] code);
    glyph_t g;
    case (code)
      8'h00: g = mk(4'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'h0A: g = mk(4'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'h20: g = mk(4'd2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'h21: g = mk(4'd2, 8'h02, 8'h02, 8'h02, 8'h00, 8'h02, 8'h00, 8'h00);
      8'h22: g = mk(4'd2, 8'h03, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'h27: g = mk(4'd1, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      8'h2C: g = mk(4'd2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h01, 8'h00);
      8'h2D: g = mk(4'd3, 8'h00, 8'h00, 8'h00, 8'h06, 8'h00, 8'h00, 8'h00);
      8'h2E: g = mk(4'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00);
      8'h3A: g = mk(4'd1, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00);
      8'h3F: g = mk(4'd3, 8'h03, 8'h04, 8'h02, 8'h00, 8'h02, 8'h00, 8'h00);
      8'hA4: g = mk(4'd4, 8'h00, 8'h00, 8'h0C, 8'h06, 8'h0C, 8'h00, 8'h00);
      8'hA6: g = mk(4'd2, 8'h02, 8'h00, 8'h02, 8'h02, 8'h02, 8'h00, 8'h00);
      8'hA7: g = mk(4'd3, 8'h05, 8'h00, 8'h02, 8'h02, 8'h02, 8'h00, 8'h00);
      8'hAD: g = mk(4'd4, 8'h00, 8'h08, 8'h0E, 8'h02, 8'h02, 8'h00, 8'h00);
      8'hB4: g = mk(4'd4, 8'h0C, 8'h02, 8'h0E, 8'h02, 8'h0C, 8'h00, 8'h00);
      8'hB6: g = mk(4'd4, 8'h0E, 8'h04, 8'h04, 8'h04, 8'h0E, 8'h00, 8'h00);
      8'hB7: g = mk(4'd4, 8'h0A, 8'h0E, 8'h04, 8'h04, 8'h0E, 8'h00, 8'h00);
      8'hBD: g = mk(4'd4, 8'h08, 8'h0E, 8'h02, 8'h02, 8'h02, 8'h00, 8'h00);
      8'hC0: g = mk(4'd5, 8'h00, 8'h00, 8'h1A, 8'h16, 8'h1A, 8'h00, 8'h00);
      8'hC1: g = mk(4'd4, 8'h00, 8'h00, 8'h0C, 8'h0A, 8'h0C, 8'h00, 8'h00);
      8'hC2: g = mk(4'd4, 8'h0C, 8'h02, 8'h06, 8'h0A, 8'h04, 8'h00, 8'h00);
      8'hC3: g = mk(4'd5, 8'h00, 8'h00, 8'h0A, 8'h0A, 8'h1C, 8'h10, 8'h00);
      8'hC4: g = mk(4'd4, 8'h00, 8'h00, 8'h0C, 8'h0A, 8'h0C, 8'h08, 8'h04);
      8'hC5: g = mk(4'd4, 8'h00, 8'h00, 8'h0E, 8'h06, 8'h0E, 8'h00, 8'h00);
      8'hC6: g = mk(4'd6, 8'h00, 8'h00, 8'h1C, 8'h2A, 8'h1C, 8'h08, 8'h08);
      8'hC7: g = mk(4'd3, 8'h00, 8'h00, 8'h06, 8'h02, 8'h02, 8'h00, 8'h00);
      8'hC8: g = mk(4'd4, 8'h00, 8'h00, 8'h0A, 8'h04, 8'h0A, 8'h00, 8'h00);
      8'hC9: g = mk(4'd4, 8'h00, 8'h00, 8'h0A, 8'h0A, 8'h0C, 8'h00, 8'h00);
      8'hCA: g = mk(4'd4, 8'h00, 8'h04, 8'h00, 8'h0A, 8'h0C, 8'h00, 8'h00);
      8'hCB: g = mk(4'd4, 8'h00, 8'h00, 8'h0A, 8'h06, 8'h0A, 8'h00, 8'h00);
      8'hCC: g = mk(4'd4, 8'h00, 8'h00, 8'h0C, 8'h0A, 8'h0A, 8'h00, 8'h00);
      8'hCD: g = mk(4'd6, 8'h00, 8'h00, 8'h22, 8'h36, 8'h2A, 8'h00, 8'h00);
      8'hCE: g = mk(4'd4, 8'h00, 8'h00, 8'h0A, 8'h0E, 8'h0A, 8'h00, 8'h00);
      8'hCF: g = mk(4'd4, 8'h00, 8'h00, 8'h0E, 8'h0A, 8'h0E, 8'h00, 8'h00);
      8'hD0: g = mk(4'd4, 8'h00, 8'h00, 8'h0E, 8'h0A, 8'h0A, 8'h00, 8'h00);
      8'hD1: g = mk(4'd4, 8'h00, 8'h00, 8'h0E, 8'h0C, 8'h0A, 8'h00, 8'h00);
      8'hD2: g = mk(4'd4, 8'h00, 8'h00, 8'h06, 8'h0A, 8'h06, 8'h02, 8'h02);
      8'hD3: g = mk(4'd4, 8'h00, 8'h00, 8'h0E, 8'h02, 8'h0E, 8'h00, 8'h00);
      8'hD4: g = mk(4'd4, 8'h00, 8'h00, 8'h0E, 8'h04, 8'h04, 8'h00, 8'h00);
      8'hD5: g = mk(4'd4, 8'h00, 8'h00, 8'h0A, 8'h0A, 8'h0C, 8'h08, 8'h04);
      8'hD6: g = mk(4'd6, 8'h00, 8'h00, 8'h2A, 8'h1C, 8'h2A, 8'h00, 8'h00);
      8'hD7: g = mk(4'd4, 8'h04, 8'h0A, 8'h06, 8'h0A, 8'h06, 8'h00, 8'h00);
      8'hD8: g = mk(4'd3, 8'h00, 8'h00, 8'h02, 8'h06, 8'h06, 8'h00, 8'h00);
      8'hDA: g = mk(4'd4, 8'h00, 8'h00, 8'h06, 8'h08, 8'h06, 8'h08, 8'h06);
      8'hDB: g = mk(4'd6, 8'h00, 8'h00, 8'h2A, 8'h2A, 8'h3C, 8'h00, 8'h00);
      8'hDD: g = mk(4'd7, 8'h00, 8'h00, 8'h2A, 8'h2A, 8'h7C, 8'h40, 8'h00);
      8'hDE: g = mk(4'd4, 8'h00, 8'h00, 8'h0A, 8'h0E, 8'h08, 8'h00, 8'h00);
      8'hE0: g = mk(4'd6, 8'h3A, 8'h2A, 8'h2E, 8'h2A, 8'h3A, 8'h00, 8'h00);
      8'hE1: g = mk(4'd4, 8'h0C, 8'h0A, 8'h0E, 8'h0A, 8'h0A, 8'h00, 8'h00);
      8'hE2: g = mk(4'd4, 8'h0E, 8'h02, 8'h06, 8'h0A, 8'h06, 8'h00, 8'h00);
      8'hE3: g = mk(4'd5, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h1C, 8'h10, 8'h00);
      8'hE4: g = mk(4'd6, 8'h18, 8'h14, 8'h14, 8'h14, 8'h3E, 8'h22, 8'h00);
      8'hE5: g = mk(4'd4, 8'h0E, 8'h02, 8'h0E, 8'h02, 8'h0E, 8'h00, 8'h00);
      8'hE6: g = mk(4'd6, 8'h1C, 8'h2A, 8'h1C, 8'h08, 8'h08, 8'h00, 8'h00);
      8'hE7: g = mk(4'd4, 8'h0E, 8'h02, 8'h02, 8'h02, 8'h02, 8'h00, 8'h00);
      8'hE8: g = mk(4'd4, 8'h0A, 8'h0A, 8'h04, 8'h0A, 8'h0A, 8'h00, 8'h00);
      8'hE9: g = mk(4'd5, 8'h12, 8'h1A, 8'h1E, 8'h16, 8'h12, 8'h00, 8'h00);
      8'hEA: g = mk(4'd5, 8'h0C, 8'h12, 8'h1A, 8'h16, 8'h12, 8'h00, 8'h00);
      8'hEB: g = mk(4'd4, 8'h0A, 8'h06, 8'h06, 8'h0A, 8'h0A, 8'h00, 8'h00);
      8'hEC: g = mk(4'd4, 8'h0C, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h00, 8'h00);
      8'hED: g = mk(4'd6, 8'h22, 8'h36, 8'h2A, 8'h2A, 8'h22, 8'h00, 8'h00);
      8'hEE: g = mk(4'd4, 8'h0A, 8'h0A, 8'h0E, 8'h0A, 8'h0A, 8'h00, 8'h00);
      8'hEF: g = mk(4'd4, 8'h04, 8'h0A, 8'h0A, 8'h0A, 8'h04, 8'h00, 8'h00);
      8'hF0: g = mk(4'd4, 8'h0E, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h00, 8'h00);
      8'hF1: g = mk(4'd4, 8'h0C, 8'h0A, 8'h0C, 8'h0A, 8'h0A, 8'h00, 8'h00);
      8'hF2: g = mk(4'd4, 8'h06, 8'h0A, 8'h06, 8'h02, 8'h02, 8'h00, 8'h00);
      8'hF3: g = mk(4'd4, 8'h0C, 8'h02, 8'h02, 8'h02, 8'h0C, 8'h00, 8'h00);
      8'hF4: g = mk(4'd4, 8'h0E, 8'h04, 8'h04, 8'h04, 8'h04, 8'h00, 8'h00);
      8'hF5: g = mk(4'd4, 8'h0A, 8'h0A, 8'h0E, 8'h08, 8'h0E, 8'h00, 8'h00);
      8'hF6: g = mk(4'd6, 8'h2A, 8'h2A, 8'h1C, 8'h2A, 8'h2A, 8'h00, 8'h00);
      8'hF7: g = mk(4'd4, 8'h0E, 8'h0A, 8'h06, 8'h0A, 8'h0E, 8'h00, 8'h00);
      8'hF8: g = mk(4'd4, 8'h02, 8'h02, 8'h06, 8'h0A, 8'h06, 8'h00, 8'h00);
      8'hFA: g = mk(4'd4, 8'h06, 8'h08, 8'h06, 8'h08, 8'h06, 8'h00, 8'h00);
      8'hFB: g = mk(4'd6, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h3C, 8'h00, 8'h00);
      8'hFD: g = mk(4'd7, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h7C, 8'h40, 8'h00);
      8'hFE: g = mk(4'd4, 8'h0A, 8'h0A, 8'h0C, 8'h08, 8'h08, 8'h00, 8'h00);
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== src/lmgbs_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data
module lmgbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/lmgbs_shift.sv =====
`default_nettype none

// Shared column shifter: left for a positive offset, right otherwise
module lmgbs_shift
  import lmgbs_pkg::*;
(
  input  wire logic [PIX_W-1:0] data_i,
  input  wire logic signed [3:0] shamt_i,
  output logic      [PIX_W-1:0] data_o
);

  logic [3:0] neg_amt;

  assign neg_amt = 4'(-shamt_i);

  always_comb begin
    if (shamt_i > 4'sd0) begin
      data_o = data_i << shamt_i[2:0];
    end else begin
      data_o = data_i >> neg_amt[2:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/led_matrix_glyph_blit_and_scan_unit.sv =====
// 8x8 LED matrix frame buffer with glyph blitter and row-scan output.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one command per
// transaction: set pixel, clear pixel, clear frame, blit glyph, scan tick.
// Every command gives exactly one result on the output channel
// (out_valid_o/out_ready_i/out_data_o): the drive word for a tick, the glyph
// width for a blit, zero otherwise.
// Commands run one at a time under a small sequencer; in_ready_o is high
// only while the sequencer is idle. On the way from input transaction to
// result register, clear frame and unused codes go straight to S_DONE,
// set/clear pixel pass through S_PIX and tick through S_TICK; a blit
// takes S_MASK, then S_BLIT writes one frame row per cycle through the
// shared shifter with the row RAM read one row ahead; an out-of-view blit
// skips S_BLIT. The next command is taken after S_DONE returns to idle.
// The result register decouples the two sides: a new command is accepted
// while a result waits, and the sequencer stalls in its final step only
// if a second result is ready before the first is taken.
// Reset clears the frame (per-row valid bits, no clearing pass), the scan
// row counter and the handshake state.
`default_nettype none

module led_matrix_glyph_blit_and_scan_unit
  import lmgbs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  state_e               state_q, state_d;
  in_t                  cmd_q, cmd_d;
  glyph_t               glyph_q, glyph_d;
  logic [PIX_W-1:0]     mask_q, mask_d;
  logic [ROW_W-1:0]     idx_q, idx_d;
  logic [ROW_W-1:0]     scan_q, scan_d;
  logic [SCAN_ROWS-1:0] valid_q, valid_d;
  logic                 rd_ok_q, rd_ok_d;
  out_t                 res_q, res_d;
  out_t                 out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic                 in_fire;
  logic                 ram_we, ram_re;
  logic [ROW_W-1:0]     ram_waddr, ram_raddr;
  logic [PIX_W-1:0]     ram_wdata, ram_rdata, row_data;
  logic [PIX_W-1:0]     sh_in, sh_out, pix_bit;
  logic signed [8:0]    reach;
  logic                 out_of_view;

  // Frame rows
  lmgbs_ram #(
    .WIDTH(PIX_W),
    .DEPTH(SCAN_ROWS)
  ) u_frame (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  lmgbs_shift u_shift (
    .data_i (sh_in),
    .shamt_i(cmd_q.shift_amount[3:0]),
    .data_o (sh_out)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A row that was never written since reset or clear reads as blank
  assign row_data = rd_ok_q ? ram_rdata : '0;
  assign pix_bit  = PIX_W'(1) << cmd_q.col;

  // Visibility: offset below the right edge and offset+width past the left
  assign reach = {cmd_q.shift_amount[7], cmd_q.shift_amount}
               + {5'd0, glyph_q.width};
  assign out_of_view = (!cmd_q.shift_amount[7] && (cmd_q.shift_amount[6:3] != 4'd0))
                    || reach[8] || (reach == 9'sd0);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    glyph_d     = glyph_q;
    mask_d      = mask_q;
    idx_d       = idx_q;
    scan_d      = scan_q;
    valid_d     = valid_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    sh_in       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_d   = in_data_i;
          glyph_d = glyph_rom(in_data_i.char_code);
          res_d   = '0;
          ram_re  = 1'b1;
          if (in_data_i.func == FUNC_TICK) begin
            ram_raddr = scan_q;
          end else if (in_data_i.func == FUNC_BLIT) begin
            ram_raddr = '0;
          end else begin
            ram_raddr = in_data_i.row;
          end
          case (in_data_i.func)
            FUNC_SET, FUNC_CLR: state_d = S_PIX;
            FUNC_TICK:          state_d = S_TICK;
            FUNC_BLIT:          state_d = S_MASK;
            FUNC_CLEAR: begin
              valid_d = '0;
              state_d = S_DONE;
            end
            default:            state_d = S_DONE;
          endcase
        end
      end

      // Read-modify-write of one pixel
      S_PIX: begin
        ram_we    = 1'b1;
        ram_waddr = cmd_q.row;
        ram_wdata = (cmd_q.func == FUNC_SET) ? (row_data | pix_bit)
                                             : (row_data & ~pix_bit);
        valid_d[cmd_q.row] = 1'b1;
        state_d   = S_DONE;
      end

      // Active-low row select over the row data, then advance the scan
      S_TICK: begin
        res_d.drive_word = {~(ROW_SEL_IDLE & (8'd1 << scan_q)), row_data};
        scan_d  = scan_q + ROW_W'(1);
        state_d = S_DONE;
      end

      // Column mask through the shifter
      S_MASK: begin
        res_d.glyph_width = glyph_q.width;
        sh_in  = 8'hFF >> (4'd8 - glyph_q.width);
        mask_d = sh_out;
        idx_d  = '0;
        state_d = out_of_view ? S_DONE : S_BLIT;
      end

      // One frame row per cycle; the next row is read alongside
      S_BLIT: begin
        sh_in     = (idx_q == '0) ? '0 : glyph_q.rows[idx_q - ROW_W'(1)];
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = (row_data & ~mask_q) | sh_out;
        valid_d[idx_q] = 1'b1;
        if (idx_q == ROW_W'(SCAN_ROWS - 1)) begin
          state_d = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_q + ROW_W'(1);
          idx_d     = idx_q + ROW_W'(1);
        end
      end

      // Hand the result over once the output register is free
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    rd_ok_d = ram_re ? valid_q[ram_raddr] : rd_ok_q;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    glyph_q <= glyph_d;
    mask_q  <= mask_d;
    idx_q   <= idx_d;
    rd_ok_q <= rd_ok_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

endmodule

`default_nettype wire

// ===== src/lmgbs_checker.sv =====
`default_nettype none
`include "led_matrix_glyph_blit_and_scan_unit_defines.svh"

// Port-level checks on the matrix controller
module lmgbs_checker
  import lmgbs_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_data_o
);

  // A result is held until taken
  `LMGBS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")

  // One command at a time: busy right after a transaction
  `LMGBS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "second command taken while busy")

  // A result carries a drive word or a width, never both
  `LMGBS_ASSERT_NOW(a_one_kind, out_valid_o, (out_data_o.drive_word == 16'd0) || (out_data_o.glyph_width == 4'd0), "drive word and width both set")

  // Glyph widths stay within the matrix
  `LMGBS_ASSERT_NOW(a_width_range, out_valid_o, out_data_o.glyph_width <= 4'd8, "glyph width beyond eight")

  // A tick selects exactly one row (one low bit)
  `LMGBS_ASSERT_NOW(a_one_row, out_valid_o && (out_data_o.drive_word[15:8] != 8'd0), $countones(out_data_o.drive_word[15:8]) == 7, "row select not one-cold")

endmodule

bind led_matrix_glyph_blit_and_scan_unit lmgbs_checker u_checker (.*);

`default_nettype wire
